[src/sbsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsm_pkg: shared types and constants for the serial bank switch mapper
// Holds the bus command codes, register selects, the controller state type
// and the command/status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package sbsm_pkg;

    // Bus command codes carried in the input tuser field.
    localparam logic [1:0] CMD_CPU_READ  = 2'd0;
    localparam logic [1:0] CMD_CPU_WRITE = 2'd1;
    localparam logic [1:0] CMD_PPU_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic REG_PRG_COUNT = 1'b0;
    localparam logic REG_CHR_COUNT = 1'b1;

    // Target of a completed serial load, from address bits 14:13.
    localparam logic [1:0] SEL_CONTROL  = 2'd0;
    localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
    localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
    localparam logic [1:0] SEL_PRG_BANK = 2'd3;

    // PRG banking modes, from control bits 3:2.
    localparam logic [1:0] PRG_MODE_32K_A    = 2'd0;
    localparam logic [1:0] PRG_MODE_32K_B    = 2'd1;
    localparam logic [1:0] PRG_MODE_FIX_LOW  = 2'd2;
    localparam logic [1:0] PRG_MODE_FIX_HIGH = 2'd3;

    // Bank count limits and reset values.
    localparam logic [5:0] MAX_PRG_BANKS   = 6'd32;
    localparam logic [4:0] MAX_CHR_BANKS   = 5'd16;
    localparam logic [5:0] PRG_COUNT_RESET = 6'd16;
    localparam logic [4:0] CHR_COUNT_RESET = 5'd0;

    // Serial load and control register constants.
    localparam logic [4:0] SHIFT_EMPTY    = 5'h10;
    localparam logic [4:0] CONTROL_RESET  = 5'h0C;
    localparam logic [4:0] CONTROL_FIXHI  = 5'h0C;

    // The remainder unit retires two dividend bits per step.
    localparam int unsigned DIV_STEPS = 3;
    localparam logic [1:0]  DIV_LAST  = 2'(DIV_STEPS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the accepted input item
        logic setup;     // apply a write and load the remainder unit
        logic div_step;  // run one remainder step
        logic out_load;  // load the result register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic needs_div; // the held item is a read that maps to an offset
    } dp_status_t;

endpackage

[src/sbsm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsm_ctrl: sequencing controller for the bank mapper
// Accepts one item at a time, steps the remainder unit for mapped reads and
// loads the output register when it is free.
// ----------------------------------------------------------------------------
module sbsm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output sbsm_pkg::dp_cmd_t     cmd,
    input  sbsm_pkg::dp_status_t  status
);
    import sbsm_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;

    // State, step counter and output valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup = 1'b1;
                cnt_next  = '0;
                state_next = status.needs_div ? ST_DIVIDE : ST_FINISH;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 2'd1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The result stays valid until the consumer takes it.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

[src/sbsm_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsm_datapath: mapper registers, serial loader and offset arithmetic
// Holds the bank registers and bank counts, applies CPU writes, reduces the
// selected bank modulo the bank count with a two-bit-per-step remainder unit
// and builds the result item.
// ----------------------------------------------------------------------------
module sbsm_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sbsm_pkg::dp_cmd_t     cmd,
    output sbsm_pkg::dp_status_t  status,
    input  logic [1:0]            in_cmd,
    input  logic [15:0]           in_address,
    input  logic [7:0]            in_write_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_index,
    input  logic [5:0]            cfg_data,
    output logic                  out_mapped_valid,
    output logic [18:0]           out_mapped_offset,
    output logic [1:0]            out_mirroring
);
    import sbsm_pkg::*;

    // Held input item.
    logic [1:0]  cmd_reg;
    logic [15:0] addr_reg;
    logic [7:0]  data_reg;

    // Configuration and mapper state.
    logic [5:0] prg_count_reg;
    logic [4:0] chr_count_reg;
    logic [4:0] shift_reg, shift_next;
    logic [4:0] control_reg, control_next;
    logic [4:0] chr_low_reg, chr_low_next;
    logic [4:0] chr_high_reg, chr_high_next;
    logic [4:0] prg_bank_reg, prg_bank_next;

    // Remainder unit.
    logic [5:0] dividend_reg, dividend_next;
    logic [5:0] divisor_reg, divisor_next;
    logic [4:0] rem_reg, rem_next;

    // Result register.
    logic        res_valid_reg;
    logic [18:0] res_offset_reg;
    logic [1:0]  res_mirror_reg;

    logic       is_prg_read;
    logic       is_chr_read;
    logic [5:0] prg_n;
    logic [4:0] prg_last;
    logic [4:0] chr_m;
    logic [4:0] prg_sel;
    logic [4:0] chr_sel;
    logic [4:0] shifted;
    logic [5:0] r1;
    logic [4:0] r1_red;
    logic [5:0] r2;

    // Kind of the held item.
    assign is_prg_read      = (cmd_reg == CMD_CPU_READ) && addr_reg[15];
    assign is_chr_read      = (cmd_reg == CMD_PPU_READ);
    assign status.needs_div = is_prg_read || is_chr_read;

    // Effective bank counts: zero counts as one, large counts saturate.
    always_comb begin
        if (prg_count_reg == 6'd0) begin
            prg_n = 6'd1;
        end else if (prg_count_reg > MAX_PRG_BANKS) begin
            prg_n = MAX_PRG_BANKS;
        end else begin
            prg_n = prg_count_reg;
        end
        if (chr_count_reg == 5'd0) begin
            chr_m = 5'd1;
        end else if (chr_count_reg > MAX_CHR_BANKS) begin
            chr_m = MAX_CHR_BANKS;
        end else begin
            chr_m = chr_count_reg;
        end
        prg_last = 5'(prg_n - 6'd1);
    end

    // PRG bank in 16 KiB units before the modulo. The fixed last bank is
    // already below the count, so it passes through the unit unchanged.
    always_comb begin
        case (control_reg[3:2]) inside
            PRG_MODE_32K_A, PRG_MODE_32K_B: begin
                prg_sel = {1'b0, prg_bank_reg[3:1], addr_reg[14]};
            end
            PRG_MODE_FIX_LOW: begin
                prg_sel = addr_reg[14] ? {1'b0, prg_bank_reg[3:0]} : 5'd0;
            end
            default: begin
                prg_sel = addr_reg[14] ? prg_last : {1'b0, prg_bank_reg[3:0]};
            end
        endcase
    end

    // CHR bank in 4 KiB units before the modulo.
    always_comb begin
        if (!control_reg[4]) begin
            chr_sel = {chr_low_reg[4:1], addr_reg[12]};
        end else if (addr_reg[12]) begin
            chr_sel = chr_high_reg;
        end else begin
            chr_sel = chr_low_reg;
        end
    end

    // Serial loader: a write with bit 7 set empties the shifter and sets control
    // bits 3:2, otherwise bit 0 shifts in and the fifth bit commits the value.
    always_comb begin
        shift_next    = shift_reg;
        control_next  = control_reg;
        chr_low_next  = chr_low_reg;
        chr_high_next = chr_high_reg;
        prg_bank_next = prg_bank_reg;
        shifted       = {data_reg[0], shift_reg[4:1]};
        if (cmd.setup && (cmd_reg == CMD_CPU_WRITE) && addr_reg[15]) begin
            if (data_reg[7]) begin
                shift_next   = SHIFT_EMPTY;
                control_next = control_reg | CONTROL_FIXHI;
            end else if (shift_reg[0]) begin
                shift_next = SHIFT_EMPTY;
                unique case (addr_reg[14:13])
                    SEL_CONTROL:  control_next  = shifted;
                    SEL_CHR_LOW:  chr_low_next  = shifted;
                    SEL_CHR_HIGH: chr_high_next = shifted;
                    SEL_PRG_BANK: prg_bank_next = shifted;
                    default:      control_next  = control_reg;
                endcase
            end else begin
                shift_next = shifted;
            end
        end
    end

    // Two restoring remainder steps per cycle; the remainder stays below
    // the divisor, so five bits hold it.
    always_comb begin
        r1     = {rem_reg, dividend_reg[5]};
        r1_red = (r1 >= divisor_reg) ? 5'(r1 - divisor_reg) : r1[4:0];
        r2     = {r1_red, dividend_reg[4]};
        dividend_next = dividend_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        if (cmd.setup) begin
            rem_next = '0;
            if (is_prg_read) begin
                dividend_next = {1'b0, prg_sel};
                divisor_next  = prg_n;
            end else begin
                dividend_next = {1'b0, chr_sel};
                divisor_next  = {chr_m, 1'b0};
            end
        end else if (cmd.div_step) begin
            rem_next      = (r2 >= divisor_reg) ? 5'(r2 - divisor_reg) : r2[4:0];
            dividend_next = {dividend_reg[3:0], 2'b00};
        end
    end

    // Control state: configuration, mapper registers and valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_count_reg <= PRG_COUNT_RESET;
            chr_count_reg <= CHR_COUNT_RESET;
            shift_reg     <= SHIFT_EMPTY;
            control_reg   <= CONTROL_RESET;
            chr_low_reg   <= '0;
            chr_high_reg  <= '0;
            prg_bank_reg  <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_PRG_COUNT: prg_count_reg <= cfg_data;
                    REG_CHR_COUNT: chr_count_reg <= cfg_data[4:0];
                    default:       prg_count_reg <= prg_count_reg;
                endcase
            end
            shift_reg    <= shift_next;
            control_reg  <= control_next;
            chr_low_reg  <= chr_low_next;
            chr_high_reg <= chr_high_next;
            prg_bank_reg <= prg_bank_next;
            if (cmd.out_load) begin
                res_valid_reg <= status.needs_div;
            end
        end
    end

    // Payload registers: held item, remainder unit and result.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg  <= in_cmd;
            addr_reg <= in_address;
            data_reg <= in_write_data;
        end
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        rem_reg      <= rem_next;
        if (cmd.out_load) begin
            res_mirror_reg <= control_reg[1:0];
            if (is_prg_read) begin
                res_offset_reg <= {rem_reg, addr_reg[13:0]};
            end else if (is_chr_read) begin
                res_offset_reg <= {2'b00, rem_reg, addr_reg[11:0]};
            end else begin
                res_offset_reg <= '0;
            end
        end
    end

    assign out_mapped_valid  = res_valid_reg;
    assign out_mapped_offset = res_offset_reg;
    assign out_mirroring     = res_mirror_reg;

endmodule

[src/serial_bank_switch_mapper_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper_unit: cartridge bank mapper with serial loading
// Top level joining the sequencing controller and the mapper datapath.
// ----------------------------------------------------------------------------
// One item is in work at a time. A CPU write, a CPU read below 0x8000 or an
// unused command passes through the setup and finish states until its result
// is loaded; a mapped read (CPU at 0x8000 or above, or any PPU read) also
// passes through the divide state, where the bank number is reduced modulo
// the bank count by a remainder unit that retires two bits per cycle. A new
// item is accepted on the cycle after the result is loaded, while that result
// may still wait in the output register. Configuration writes are always
// ready and must be issued only while the block is idle.
module serial_bank_switch_mapper_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] address, [23:16] write_data
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [18:0] mapped_offset, [20:19] mirroring, zero fill
    output logic        m_tuser,   // [0] mapped_valid
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_data
);
    import sbsm_pkg::*;

    dp_cmd_t     dp_cmd;
    dp_status_t  dp_status;
    logic [18:0] mapped_offset;
    logic [1:0]  mirroring;

    // Sequencing controller.
    sbsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (dp_cmd),
        .status   (dp_status)
    );

    // Mapper datapath.
    sbsm_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (dp_cmd),
        .status            (dp_status),
        .in_cmd            (s_tuser),
        .in_address        (s_tdata[15:0]),
        .in_write_data     (s_tdata[23:16]),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .out_mapped_valid  (m_tuser),
        .out_mapped_offset (mapped_offset),
        .out_mirroring     (mirroring)
    );

    assign cfg_ready = 1'b1;
    assign m_tdata   = {3'b000, mirroring, mapped_offset};

endmodule

[tb/sbsm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsm_checker: result predictor and scoreboard for the bank switch mapper
// Watches the input, result and configuration channels of the mapper. Each
// accepted input item runs through a cycle-free model of the serial load
// register, the bank registers and the PRG/CHR address mapping, and the
// expected result is queued. Each accepted result is compared field by field
// with the oldest queued expectation.
// ----------------------------------------------------------------------------
module sbsm_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] address, [23:16] write_data
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [18:0] mapped_offset, [20:19] mirroring, zero fill
    input  logic        m_tuser,   // [0] mapped_valid
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_data,
    output int          fail_count,
    output int          pending,
    output int          checked
);
    import sbsm_pkg::*;

    localparam logic [15:0]  CART_BASE      = 16'h8000;
    localparam logic [15:0]  UPPER_HALF     = 16'hC000;
    localparam int unsigned  PRG_BANK_BYTES = 32'h4000;
    localparam int unsigned  CHR_BANK_BYTES = 32'h2000;
    localparam int unsigned  CHR_HALF_BYTES = 32'h1000;

    typedef struct packed {
        logic        hit;
        logic [18:0] offset;
        logic [1:0]  mirror;
    } map_result_t;

    // Mapper state as seen by the predictor.
    logic [4:0] load_sr;
    logic [4:0] ctrl;
    logic [4:0] chr_bank_lo;
    logic [4:0] chr_bank_hi;
    logic [4:0] prg_sel;
    logic [5:0] prg_count;
    logic [4:0] chr_count;

    map_result_t expected_q[$];

    // Number of 16 KiB PRG banks, with zero read as one and saturation.
    function automatic int unsigned prg_bank_total();
        int unsigned n;
        n = 32'(prg_count);
        if (n == 0) n = 1;
        if (n > MAX_PRG_BANKS) n = MAX_PRG_BANKS;
        return n;
    endfunction

    // CHR memory size in bytes, with zero read as one bank and saturation.
    function automatic int unsigned chr_bytes();
        int unsigned n;
        n = 32'(chr_count);
        if (n == 0) n = 1;
        if (n > MAX_CHR_BANKS) n = MAX_CHR_BANKS;
        return n * CHR_BANK_BYTES;
    endfunction

    function automatic int unsigned prg_offset(input logic [15:0] addr);
        int unsigned banks;
        int unsigned switched;
        int unsigned low;
        int unsigned pair;
        banks    = prg_bank_total();
        switched = 32'(prg_sel[3:0]) % banks;
        low      = 32'(addr[13:0]);
        pair     = 32'(prg_sel & 5'h0E);
        case (ctrl[3:2])
            PRG_MODE_32K_A, PRG_MODE_32K_B: begin
                return (pair * PRG_BANK_BYTES + 32'(addr[14:0])) % (banks * PRG_BANK_BYTES);
            end
            PRG_MODE_FIX_LOW: begin
                if (addr < UPPER_HALF) return low;
                return switched * PRG_BANK_BYTES + low;
            end
            default: begin
                if (addr < UPPER_HALF) return switched * PRG_BANK_BYTES + low;
                return (banks - 1) * PRG_BANK_BYTES + low;
            end
        endcase
    endfunction

    function automatic int unsigned chr_offset(input logic [15:0] addr);
        int unsigned size;
        int unsigned pair;
        size = chr_bytes();
        pair = 32'(chr_bank_lo & 5'h1E);
        // 8 KiB mode ignores the low bank bit; 4 KiB mode picks by address bit 12.
        if (!ctrl[4]) return (pair * CHR_HALF_BYTES + 32'(addr[12:0])) % size;
        if (!addr[12]) begin
            return (32'(chr_bank_lo) * CHR_HALF_BYTES + 32'(addr[11:0])) % size;
        end
        return (32'(chr_bank_hi) * CHR_HALF_BYTES + 32'(addr[11:0])) % size;
    endfunction

    // Serial port write: a set bit 7 empties the shifter, otherwise one bit
    // shifts in and the fifth bit commits the value to the selected register.
    function automatic void serial_write(input logic [15:0] addr, input logic [7:0] wdata);
        logic       full;
        logic [4:0] value;
        if (addr < CART_BASE) return;
        if (wdata[7]) begin
            load_sr = SHIFT_EMPTY;
            ctrl    = ctrl | CONTROL_FIXHI;
            return;
        end
        full    = load_sr[0];
        load_sr = {wdata[0], load_sr[4:1]};
        if (!full) return;
        value = load_sr;
        case (addr[14:13])
            SEL_CONTROL:  ctrl        = value;
            SEL_CHR_LOW:  chr_bank_lo = value;
            SEL_CHR_HIGH: chr_bank_hi = value;
            default:      prg_sel     = value;
        endcase
        load_sr = SHIFT_EMPTY;
    endfunction

    function automatic map_result_t map_access(input logic [1:0] cmd, input logic [15:0] addr,
                                               input logic [7:0] wdata);
        map_result_t r;
        r = '0;
        case (cmd)
            CMD_CPU_READ: begin
                if (addr >= CART_BASE) begin
                    r.hit    = 1'b1;
                    r.offset = 19'(prg_offset(addr));
                end
            end
            CMD_CPU_WRITE: serial_write(addr, wdata);
            CMD_PPU_READ: begin
                r.hit    = 1'b1;
                r.offset = 19'(chr_offset(addr));
            end
            default: ;
        endcase
        r.mirror = ctrl[1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        map_result_t want;
        map_result_t got;
        if (!aresetn) begin
            load_sr     = SHIFT_EMPTY;
            ctrl        = CONTROL_RESET;
            chr_bank_lo = '0;
            chr_bank_hi = '0;
            prg_sel     = '0;
            prg_count   = PRG_COUNT_RESET;
            chr_count   = CHR_COUNT_RESET;
            expected_q.delete();
            fail_count  = 0;
            pending     = 0;
            checked     = 0;
        end else begin
            // Register writes are to be issued only while the mapper is idle; nothing here enforces it.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PRG_COUNT: prg_count = cfg_data;
                    REG_CHR_COUNT: chr_count = cfg_data[4:0];
                endcase
            end

            // Compare a returned result with the oldest expectation.
            if (m_tvalid && m_tready) begin
                got.hit    = m_tuser;
                got.offset = m_tdata[18:0];
                got.mirror = m_tdata[20:19];
                if (expected_q.size() == 0) begin
                    $error("unexpected result item: mapped_valid %0d mapped_offset 0x%05h",
                           got.hit, got.offset);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    checked++;
                    if (got.hit !== want.hit) begin
                        $error("mapped_valid: expected %0d, got %0d", want.hit, got.hit);
                        fail_count++;
                    end
                    if (got.offset !== want.offset) begin
                        $error("mapped_offset: expected 0x%05h, got 0x%05h",
                               want.offset, got.offset);
                        fail_count++;
                    end
                    if (got.mirror !== want.mirror) begin
                        $error("mirroring: expected %0d, got %0d", want.mirror, got.mirror);
                        fail_count++;
                    end
                end
            end

            // Predict the result of a newly accepted item.
            if (s_tvalid && s_tready) begin
                expected_q.push_back(map_access(s_tuser, s_tdata[15:0], s_tdata[23:16]));
            end
            pending = expected_q.size();
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the serial bank switch mapper
// Drives bus accesses into the mapper: a directed pass over the address
// extremes, every command and the serial load corner cases, then random
// streams of complete and broken serial loads mixed with reads, across
// several bank-count settings. Both sides stall at random; the result side
// also holds off long enough to back the mapper up. A separate checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import sbsm_pkg::*;

    localparam logic [1:0] CMD_UNUSED      = 2'd3;
    localparam int         ITEMS_PER_PHASE = 125;
    localparam int         NUM_SETTINGS    = 6;
    localparam int         SETTLE_CYCLES   = 10;
    localparam int         HOLD_START      = 2500;
    localparam int         HOLD_CYCLES     = 400;
    localparam int         STEADY_START    = 5000;
    localparam int         STEADY_END      = 7000;
    localparam int         WATCHDOG_NS     = 3_000_000;

    // Bank-count settings per phase, extremes and out-of-range values included.
    localparam logic [5:0] PRG_SETTINGS [NUM_SETTINGS] =
        '{6'd1, 6'd32, 6'd0, 6'd63, 6'd2, 6'd7};
    localparam logic [5:0] CHR_SETTINGS [NUM_SETTINGS] =
        '{6'd16, 6'd1, 6'd0, 6'd31, 6'd5, 6'h2A};

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [15:0] address, [23:16] write_data
    logic [1:0]  s_tuser;   // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [18:0] mapped_offset, [20:19] mirroring, zero fill
    logic        m_tuser;   // [0] mapped_valid
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [5:0]  cfg_data;

    int fail_count;
    int pending;
    int checked;
    int items_sent;
    int settings_applied;
    bit steady_sender;

    serial_bank_switch_mapper_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sbsm_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    // 100 MHz clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: random stalls, one long hold-off that backs the mapper up,
    // and one window that never stalls.
    initial begin
        int cycle;
        cycle    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            cycle++;
            if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_CYCLES) begin
                m_tready = 1'b0;
            end else if (cycle >= STEADY_START && cycle < STEADY_END) begin
                m_tready = 1'b1;
            end else begin
                m_tready = ($urandom_range(99) >= 14);
            end
        end
    end

    // Present one item with optional idle cycles ahead; return at the falling
    // edge after it is accepted, with tvalid still high.
    task automatic send_item(input logic [1:0] cmd, input logic [15:0] addr,
                             input logic [7:0] wdata);
        while (!steady_sender && $urandom_range(99) < 14) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {wdata, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    // Five serial writes, LSB first; only the last address picks the register.
    task automatic serial_load(input logic [15:0] target, input logic [4:0] value);
        logic [7:0]  wdata;
        logic [15:0] addr;
        for (int i = 0; i < 5; i++) begin
            wdata = {1'b0, 6'($urandom()), value[i]};
            addr  = (i == 4) ? target : {1'b1, 15'($urandom())};
            send_item(CMD_CPU_WRITE, addr, wdata);
        end
    endtask

    // Wait until every result is back and the mapper has settled.
    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [5:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
        settings_applied++;
    endtask

    // Mostly complete serial loads and reads, with broken loads and noise.
    // Writes below 0x8000 and unused commands do not count toward the target.
    task automatic random_items(input int target);
        int          counted;
        int          pick;
        int          partial;
        logic [15:0] addr;
        counted = 0;
        while (counted < target) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                serial_load({1'b1, 15'($urandom())}, 5'($urandom()));
                counted += 5;
            end else if (pick < 35) begin
                // Load cut short by a shifter reset.
                partial = $urandom_range(1, 4);
                for (int i = 0; i < partial; i++) begin
                    send_item(CMD_CPU_WRITE, {1'b1, 15'($urandom())},
                              {1'b0, 7'($urandom())});
                end
                send_item(CMD_CPU_WRITE, {1'b1, 15'($urandom())}, {1'b1, 7'($urandom())});
                counted += partial + 1;
            end else if (pick < 65) begin
                addr = ($urandom_range(99) < 85) ? {1'b1, 15'($urandom())} : 16'($urandom());
                send_item(CMD_CPU_READ, addr, 8'($urandom()));
                counted++;
            end else if (pick < 90) begin
                addr = ($urandom_range(99) < 80) ? {3'b000, 13'($urandom())} : 16'($urandom());
                send_item(CMD_PPU_READ, addr, 8'($urandom()));
                counted++;
            end else if (pick < 95) begin
                addr = 16'($urandom());
                send_item(CMD_CPU_WRITE, addr, 8'($urandom()));
                if (addr[15]) counted++;
            end else if (pick < 98) begin
                send_item(CMD_UNUSED, 16'($urandom()), 8'($urandom()));
            end else begin
                send_item(CMD_CPU_WRITE, {1'b0, 15'($urandom())}, 8'($urandom()));
            end
        end
    endtask

    // Run limit.
    initial begin
        #(WATCHDOG_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        aresetn          = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        s_tuser          = CMD_CPU_READ;
        cfg_valid        = 1'b0;
        cfg_index        = REG_PRG_COUNT;
        cfg_data         = '0;
        items_sent       = 0;
        settings_applied = 0;
        steady_sender    = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed pass at the reset bank counts.
        send_item(CMD_CPU_READ, 16'h8000, 8'h00);
        send_item(CMD_CPU_READ, 16'hFFFF, 8'hFF);
        send_item(CMD_CPU_READ, 16'h0000, 8'h00);
        send_item(CMD_CPU_READ, 16'h7FFF, 8'h00);
        send_item(CMD_PPU_READ, 16'h0000, 8'h00);
        send_item(CMD_PPU_READ, 16'hFFFF, 8'h00);
        send_item(CMD_UNUSED, 16'hFFFF, 8'hFF);
        send_item(CMD_CPU_WRITE, 16'h7FFF, 8'h01);
        send_item(CMD_CPU_WRITE, 16'hFFFF, 8'hFF);
        // Control: 4 KiB CHR, fixed-last PRG, horizontal mirroring.
        serial_load(16'h8000, 5'h1F);
        serial_load(16'hE000, 5'h1F);
        serial_load(16'hA000, 5'h13);
        send_item(CMD_PPU_READ, 16'h1FFF, 8'h00);
        send_item(CMD_CPU_READ, 16'hC000, 8'h00);

        random_items(ITEMS_PER_PHASE);
        for (int p = 0; p < NUM_SETTINGS; p++) begin
            drain();
            write_reg(REG_PRG_COUNT, PRG_SETTINGS[p]);
            write_reg(REG_CHR_COUNT, CHR_SETTINGS[p]);
            steady_sender = (p == 3);
            random_items(ITEMS_PER_PHASE);
        end
        steady_sender = 1'b0;
        drain();
        write_reg(REG_PRG_COUNT, 6'($urandom_range(1, 32)));
        write_reg(REG_CHR_COUNT, 6'($urandom_range(0, 16)));
        random_items(ITEMS_PER_PHASE);
        drain();

        $display("Sent %0d bus accesses over %0d register writes; %0d results compared.",
                 items_sent, settings_applied, checked);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
